FILE: rtl/snp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_pkg: shared types, constants and functions
// Result codes, register indexes, frame state and the rotating xor check.
// ----------------------------------------------------------------------------
package snp_pkg;

	// configuration registers
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 2'd1;
	localparam logic [CFG_DATA_W-1:0] MAX_FRAME_RST = 9'd258;

	// direction values
	localparam logic DIR_BUILD = 1'b0;
	localparam logic DIR_PARSE = 1'b1;

	// control, length and check bytes around the data
	localparam logic [9:0] FRAME_OVERHEAD = 10'd3;
	// index of the first data byte in a received frame
	localparam logic [9:0] PARSE_DATA_POS = 10'd2;

	// result queue
	localparam int RES_MAX = 3;
	localparam int RES_CNT_W = 2;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;
	// most results the queue may hold for a new item to enter
	localparam logic [Q_CNT_W-1:0] Q_ACCEPT_MAX = Q_CNT_W'(Q_DEPTH - RES_MAX);

	typedef enum logic [2:0] {
		KIND_CONTROL = 3'd0,
		KIND_LENGTH  = 3'd1,
		KIND_DATA    = 3'd2,
		KIND_BCC     = 3'd3,
		KIND_STATUS  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CAPACITY = 2'd1,
		ST_SHORT    = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] byte_out;
		kind_t      kind;
		status_t    status;
		logic       frame_end;
	} res_t;

	typedef struct packed {
		res_t [RES_MAX-1:0]   res;
		logic [RES_CNT_W-1:0] cnt;
	} res_set_t;

	typedef struct packed {
		logic [8:0] position;
		logic [7:0] length_held;
		logic [7:0] acc;
		logic       discarding;
		logic       frame_done;
	} frame_state_t;

	localparam frame_state_t FRAME_CLEAR = '0;

	// xor the byte in, then rotate left by one
	function automatic logic [7:0] bcc_update(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] x;
		x = acc ^ b;
		return {x[6:0], x[7]};
	endfunction

	function automatic res_t make_res(input logic [7:0] b, input kind_t k,
			input status_t st, input logic fend);
		res_t r;
		r.byte_out  = b;
		r.kind      = k;
		r.status    = st;
		r.frame_end = fend;
		return r;
	endfunction

endpackage

FILE: rtl/snp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_in_if: input byte channel
// Valid/ready channel carrying one frame byte with its header count and flag.
// ----------------------------------------------------------------------------
interface snp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic [7:0] data_count;
	logic       last_in;

	modport source (output valid, output byte_in, output data_count, output last_in,
		input ready);
	modport sink (input valid, input byte_in, input data_count, input last_in,
		output ready);
endinterface

FILE: rtl/snp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_out_if: result channel
// Valid/ready channel carrying one emitted byte with its kind and status.
// ----------------------------------------------------------------------------
interface snp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] kind;
	logic [1:0] status;
	logic       frame_end;

	modport source (output valid, output byte_out, output kind, output status,
		output frame_end, input ready);
	modport sink (input valid, input byte_out, input kind, input status,
		input frame_end, output ready);
endinterface

FILE: rtl/snp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface snp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [snp_pkg::CFG_IDX_W-1:0]  index;
	logic [snp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/snp_frame_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_frame_codec_core: serial frame builder and checker
// Builds or parses control, length, data, BCC frames with a rotating xor BCC.
// ----------------------------------------------------------------------------
// A request is taken in every cycle while the four-entry result queue holds at
// most one result and no configuration write is offered; each request is
// handled in the cycle it is taken and its results show on the result channel
// from the next cycle, one per cycle while the result side is ready. Most data
// and parse bytes make one result and, with the result side ready, stream at one
// request per cycle. A build header makes one to three results, and a byte that
// closes a build frame not being discarded or ends a received buffer early makes
// two, so the request after one of two or three results waits as the queue drains.
// Configuration writes are always ready and take effect in the next cycle;
// writing direction drops any frame in progress.
module snp_frame_codec_core (
	input  logic       clk,
	input  logic       arst_n,
	snp_in_if.sink     item,
	snp_out_if.source  result,
	snp_cfg_if.sink    cfg
);

	snp_pkg::frame_state_t          state_q;
	snp_pkg::frame_state_t          state_nxt;
	snp_pkg::res_set_t              rset;
	snp_pkg::res_t                  head;
	logic                           direction_q;
	logic [snp_pkg::CFG_DATA_W-1:0] max_frame_q;
	logic                           room;
	logic                           take;
	logic                           cfg_wr;

	// a configuration write holds off the request channel for its cycle
	assign cfg.ready  = 1'b1;
	assign cfg_wr     = cfg.valid && cfg.ready;
	assign item.ready = room && !cfg.valid;
	assign take       = item.valid && item.ready;

	// per-byte frame logic
	snp_step u_step (
		.cur        (state_q),
		.direction  (direction_q),
		.max_frame  (max_frame_q),
		.byte_in    (item.byte_in),
		.data_count (item.data_count),
		.last_in    (item.last_in),
		.nxt        (state_nxt),
		.rset       (rset)
	);

	// registers and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= snp_pkg::DIR_BUILD;
			max_frame_q <= snp_pkg::MAX_FRAME_RST;
			state_q     <= snp_pkg::FRAME_CLEAR;
		end else if (cfg_wr) begin
			case (cfg.index)
				snp_pkg::REG_DIRECTION: begin
					direction_q <= cfg.data[0];
					state_q     <= snp_pkg::FRAME_CLEAR;
				end
				snp_pkg::REG_MAX_FRAME: begin
					max_frame_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	// result queue
	snp_res_q u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take && !cfg_wr),
		.rset   (rset),
		.room   (room),
		.valid  (result.valid),
		.ready  (result.ready),
		.head   (head)
	);

	assign result.byte_out  = head.byte_out;
	assign result.kind      = head.kind;
	assign result.status    = head.status;
	assign result.frame_end = head.frame_end;

endmodule

FILE: rtl/snp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_step: per-byte frame logic
// From the frame state and one input byte, works out the next state and the
// up to three results that the byte produces, in build or parse direction.
// ----------------------------------------------------------------------------
module snp_step (
	input  snp_pkg::frame_state_t            cur,
	input  logic                             direction,
	input  logic [snp_pkg::CFG_DATA_W-1:0]   max_frame,
	input  logic [7:0]                       byte_in,
	input  logic [7:0]                       data_count,
	input  logic                             last_in,
	output snp_pkg::frame_state_t            nxt,
	output snp_pkg::res_set_t                rset
);

	logic [7:0]  acc_data;
	logic [7:0]  acc_hdr;
	logic [8:0]  pos_inc;
	logic [9:0]  need_len;
	logic [9:0]  data_end;

	// shared arithmetic
	assign acc_data = snp_pkg::bcc_update(cur.acc, byte_in);
	assign acc_hdr  = snp_pkg::bcc_update(snp_pkg::bcc_update(8'd0, byte_in), data_count);
	assign pos_inc  = cur.position + 9'd1;
	assign need_len = snp_pkg::FRAME_OVERHEAD + {2'b00, data_count};
	assign data_end = snp_pkg::PARSE_DATA_POS + {2'b00, cur.length_held};

	// next state and results
	always_comb begin
		nxt      = cur;
		rset.res = '0;
		rset.cnt = '0;
		if (direction == snp_pkg::DIR_BUILD) begin
			if (cur.position == 9'd0) begin
				// header item
				nxt.length_held = data_count;
				if (need_len > {1'b0, max_frame}) begin
					rset.res[0] = snp_pkg::make_res(8'd0, snp_pkg::KIND_STATUS,
						snp_pkg::ST_CAPACITY, 1'b1);
					rset.cnt       = 2'd1;
					nxt.discarding = (data_count != 8'd0);
					nxt.position   = (data_count != 8'd0) ? 9'd1 : 9'd0;
				end else begin
					nxt.discarding = 1'b0;
					nxt.acc        = acc_hdr;
					rset.res[0] = snp_pkg::make_res(byte_in, snp_pkg::KIND_CONTROL,
						snp_pkg::ST_OK, 1'b0);
					rset.res[1] = snp_pkg::make_res(data_count, snp_pkg::KIND_LENGTH,
						snp_pkg::ST_OK, 1'b0);
					if (data_count == 8'd0) begin
						rset.res[2] = snp_pkg::make_res(acc_hdr, snp_pkg::KIND_BCC,
							snp_pkg::ST_OK, 1'b1);
						rset.cnt     = 2'd3;
						nxt.position = 9'd0;
					end else begin
						rset.cnt     = 2'd2;
						nxt.position = 9'd1;
					end
				end
			end else begin
				// data item, dropped while discarding
				if (!cur.discarding) begin
					nxt.acc = acc_data;
					rset.res[0] = snp_pkg::make_res(byte_in, snp_pkg::KIND_DATA,
						snp_pkg::ST_OK, 1'b0);
					rset.cnt = 2'd1;
				end
				nxt.position = pos_inc;
				if (cur.position >= {1'b0, cur.length_held}) begin
					if (!cur.discarding) begin
						rset.res[1] = snp_pkg::make_res(acc_data, snp_pkg::KIND_BCC,
							snp_pkg::ST_OK, 1'b1);
						rset.cnt = 2'd2;
					end
					nxt.position   = 9'd0;
					nxt.discarding = 1'b0;
				end
			end
		end else begin
			if (cur.frame_done) begin
				// skip trailing bytes up to the end of the buffer
				if (last_in) begin
					nxt = snp_pkg::FRAME_CLEAR;
				end
			end else if ({1'b0, cur.position} >= data_end && cur.position >= 9'd2) begin
				// check byte
				rset.res[0] = snp_pkg::make_res(byte_in, snp_pkg::KIND_BCC,
					(byte_in == cur.acc) ? snp_pkg::ST_OK : snp_pkg::ST_MISMATCH, 1'b1);
				rset.cnt = 2'd1;
				if (last_in) begin
					nxt = snp_pkg::FRAME_CLEAR;
				end else begin
					nxt.frame_done = 1'b1;
				end
			end else begin
				// control, length or data byte passes through
				nxt.acc = acc_data;
				if (cur.position == 9'd0) begin
					rset.res[0] = snp_pkg::make_res(byte_in, snp_pkg::KIND_CONTROL,
						snp_pkg::ST_OK, 1'b0);
					nxt.acc      = snp_pkg::bcc_update(8'd0, byte_in);
					nxt.position = 9'd1;
				end else if (cur.position == 9'd1) begin
					rset.res[0] = snp_pkg::make_res(byte_in, snp_pkg::KIND_LENGTH,
						snp_pkg::ST_OK, 1'b0);
					nxt.length_held = byte_in;
					nxt.position    = 9'd2;
				end else begin
					rset.res[0] = snp_pkg::make_res(byte_in, snp_pkg::KIND_DATA,
						snp_pkg::ST_OK, 1'b0);
					nxt.position = pos_inc;
				end
				rset.cnt = 2'd1;
				// buffer ended before the check byte
				if (last_in) begin
					rset.res[1] = snp_pkg::make_res(8'd0, snp_pkg::KIND_STATUS,
						snp_pkg::ST_SHORT, 1'b1);
					rset.cnt = 2'd2;
					nxt      = snp_pkg::FRAME_CLEAR;
				end
			end
		end
	end

endmodule

FILE: rtl/snp_res_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_res_q: result queue
// Four-entry register queue that takes up to three results in a cycle and
// hands out one per cycle on the result channel while the result side is ready.
// ----------------------------------------------------------------------------
module snp_res_q (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  snp_pkg::res_set_t   rset,
	output logic                room,
	output logic                valid,
	input  logic                ready,
	output snp_pkg::res_t       head
);

	snp_pkg::res_t                 mem_q [snp_pkg::Q_DEPTH];
	logic [snp_pkg::Q_PTR_W-1:0]   wr_q;
	logic [snp_pkg::Q_PTR_W-1:0]   rd_q;
	logic [snp_pkg::Q_CNT_W-1:0]   cnt_q;
	logic [snp_pkg::RES_CNT_W-1:0] push_n;
	logic                          pop;

	assign push_n = push ? rset.cnt : '0;
	assign pop    = valid && ready;
	assign valid  = (cnt_q != '0);
	assign room   = (cnt_q <= snp_pkg::Q_ACCEPT_MAX);
	assign head   = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < snp_pkg::RES_MAX; k++) begin
			if (snp_pkg::RES_CNT_W'(k) < push_n) begin
				mem_q[wr_q + snp_pkg::Q_PTR_W'(k)] <= rset.res[k];
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + snp_pkg::Q_PTR_W'(push_n);
			rd_q  <= rd_q + snp_pkg::Q_PTR_W'(pop);
			cnt_q <= cnt_q + snp_pkg::Q_CNT_W'(push_n) - snp_pkg::Q_CNT_W'(pop);
		end
	end

endmodule

FILE: rtl/snp_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snp_chk: port checker
// Watches the result channel of the frame codec for malformed results.
// ----------------------------------------------------------------------------
module snp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [7:0] byte_out,
	input logic [2:0] kind,
	input logic [1:0] status,
	input logic       frame_end
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable({byte_out, kind, status, frame_end}))
		else $error("result changed while stalled");

	// status-only results end a frame and carry no byte
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == snp_pkg::KIND_STATUS |-> frame_end && byte_out == 8'd0)
		else $error("status-only result malformed");

	// only the frame end carries a nonzero status
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !frame_end |-> status == snp_pkg::ST_OK)
		else $error("status outside frame end");

	// check byte always closes a frame, and only a check byte can mismatch
	a_bcc_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == snp_pkg::KIND_BCC || status == snp_pkg::ST_MISMATCH)
		|-> frame_end && kind == snp_pkg::KIND_BCC)
		else $error("check byte result malformed");

endmodule

bind snp_frame_codec_core snp_chk u_snp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (result.valid),
	.ready     (result.ready),
	.byte_out  (result.byte_out),
	.kind      (result.kind),
	.status    (result.status),
	.frame_end (result.frame_end)
);

FILE: test/tb_snp_frame_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_snp_frame_codec_core: self-checking bench for the serial frame codec
// Walks a directed stimulus table, then random build and parse frames under
// several register settings; every result is checked against typed or modelled results.
// ----------------------------------------------------------------------------
module tb_snp_frame_codec_core;
	import snp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 500;
	localparam int MAX_WAIT = 17;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	// row without typed results, checked against the model
	localparam int PRED = -1;
	localparam res_t NO_RES = '0;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] wdata;
		logic [7:0]            b;
		logic [7:0]            cnt;
		logic                  last;
		int                    fill;
		int                    n_fix;
		res_t [RES_MAX-1:0]    fix;
	} stim_row_t;

	logic clk;
	logic arst_n;

	snp_in_if  item_ch();
	snp_out_if res_ch();
	snp_cfg_if cfg_ch();

	snp_frame_codec_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// model registers and frame state
	logic       cfg_dir;
	logic [8:0] cfg_max;
	logic [8:0] fr_pos;
	logic [7:0] fr_len;
	logic [7:0] fr_bcc;
	logic       fr_drop;
	logic       fr_done;

	res_t      frame_results[$];
	stim_row_t dir_rows[$];
	res_t      want;
	int        errors;
	int        sent_items;
	bit        snd_burst;
	bit        rcv_burst;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// xor in, rotate left by one
	function automatic logic [7:0] rot_xor(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] x;
		x = acc ^ b;
		return (x << 1) | (x >> 7);
	endfunction

	function automatic res_t res_of(input logic [7:0] b, input kind_t k, input status_t s,
			input logic e);
		res_t v;
		v.byte_out  = b;
		v.kind      = k;
		v.status    = s;
		v.frame_end = e;
		return v;
	endfunction

	function automatic void clear_frame();
		fr_pos  = '0;
		fr_len  = '0;
		fr_bcc  = '0;
		fr_drop = 1'b0;
		fr_done = 1'b0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_DIRECTION: begin
				cfg_dir = val[0];
				clear_frame();
			end
			REG_MAX_FRAME: begin
				cfg_max = val;
			end
			default: begin
			end
		endcase
	endfunction

	// expected results of one request, advancing the model state
	function automatic int frame_step(input logic [7:0] b, input logic [7:0] cnt,
			input logic last, output res_t [RES_MAX-1:0] r);
		int n;
		n = 0;
		r = '0;
		if (cfg_dir == DIR_BUILD) begin
			// header item
			if (fr_pos == 9'd0) begin
				fr_len = cnt;
				if (int'(FRAME_OVERHEAD) + int'(cnt) > int'(cfg_max)) begin
					r[0] = res_of(8'h00, KIND_STATUS, ST_CAPACITY, 1'b1);
					fr_drop = (cnt != 8'd0);
					fr_pos = (cnt != 8'd0) ? 9'd1 : 9'd0;
					return 1;
				end
				fr_drop = 1'b0;
				fr_bcc = rot_xor(rot_xor(8'h00, b), cnt);
				r[0] = res_of(b, KIND_CONTROL, ST_OK, 1'b0);
				r[1] = res_of(cnt, KIND_LENGTH, ST_OK, 1'b0);
				if (cnt == 8'd0) begin
					r[2] = res_of(fr_bcc, KIND_BCC, ST_OK, 1'b1);
					return 3;
				end
				fr_pos = 9'd1;
				return 2;
			end
			// data item, dropped after an overflow
			if (!fr_drop) begin
				fr_bcc = rot_xor(fr_bcc, b);
				r[0] = res_of(b, KIND_DATA, ST_OK, 1'b0);
				n = 1;
			end
			fr_pos = fr_pos + 9'd1;
			if (int'(fr_pos) - 1 >= int'(fr_len)) begin
				if (!fr_drop) begin
					r[n] = res_of(fr_bcc, KIND_BCC, ST_OK, 1'b1);
					n++;
				end
				fr_pos = '0;
				fr_drop = 1'b0;
			end
			return n;
		end
		// parse: skip trailing bytes until the buffer ends
		if (fr_done) begin
			if (last)
				clear_frame();
			return 0;
		end
		if (fr_pos == 9'd0) begin
			fr_bcc = rot_xor(8'h00, b);
			r[0] = res_of(b, KIND_CONTROL, ST_OK, 1'b0);
			fr_pos = 9'd1;
		end else if (fr_pos == 9'd1) begin
			fr_len = b;
			fr_bcc = rot_xor(fr_bcc, b);
			r[0] = res_of(b, KIND_LENGTH, ST_OK, 1'b0);
			fr_pos = 9'd2;
		end else if (int'(fr_pos) < int'(PARSE_DATA_POS) + int'(fr_len)) begin
			fr_bcc = rot_xor(fr_bcc, b);
			r[0] = res_of(b, KIND_DATA, ST_OK, 1'b0);
			fr_pos = fr_pos + 9'd1;
		end else begin
			r[0] = res_of(b, KIND_BCC, (b == fr_bcc) ? ST_OK : ST_MISMATCH, 1'b1);
			if (last)
				clear_frame();
			else
				fr_done = 1'b1;
			return 1;
		end
		n = 1;
		// buffer ended before the check byte
		if (last) begin
			r[1] = res_of(8'h00, KIND_STATUS, ST_SHORT, 1'b1);
			n = 2;
			clear_frame();
		end
		return n;
	endfunction

	// mostly short frames, now and then up to the full count
	function automatic logic [7:0] pick_count();
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 10));
	endfunction

	// directed table rows
	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.wdata = val;
		dir_rows.push_back(row);
	endtask

	task automatic add_fixed(input logic [7:0] b, input logic [7:0] cnt, input logic last,
			input int fill, input int n, input res_t r0, input res_t r1, input res_t r2);
		stim_row_t row;
		row = '{default: '0};
		row.b = b;
		row.cnt = cnt;
		row.last = last;
		row.fill = fill;
		row.n_fix = n;
		row.fix = {r2, r1, r0};
		dir_rows.push_back(row);
	endtask

	task automatic add_pred(input logic [7:0] b, input logic [7:0] cnt, input logic last,
			input int fill);
		add_fixed(b, cnt, last, fill, PRED, NO_RES, NO_RES, NO_RES);
	endtask

	// one input request; typed results replace the model's when given
	task automatic send_item(input logic [7:0] b, input logic [7:0] cnt, input logic last,
			input int n_fix, input res_t [RES_MAX-1:0] fix);
		int gap;
		int n;
		int k;
		res_t [RES_MAX-1:0] got;
		gap = snd_burst ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.byte_in    <= b;
		item_ch.data_count <= cnt;
		item_ch.last_in    <= last;
		do @(posedge clk); while (!item_ch.ready);
		n = frame_step(b, cnt, last, got);
		if (n_fix >= 0) begin
			n = n_fix;
			got = fix;
		end
		for (k = 0; k < n; k++)
			frame_results.push_back(got[k]);
		sent_items++;
	endtask

	// wait until the block has drained
	task automatic settle();
		@(negedge clk) item_ch.valid <= 1'b0;
		while (frame_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, val);
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	// random build frame, sometimes cut short
	task automatic gen_build_frame();
		logic [7:0] cnt;
		int n_data;
		cnt = pick_count();
		n_data = cnt;
		if ($urandom_range(0, 9) == 0)
			n_data = $urandom_range(0, int'(cnt));
		send_item(8'($urandom), cnt, 1'($urandom), PRED, '0);
		repeat (n_data)
			send_item(8'($urandom), 8'($urandom), 1'($urandom), PRED, '0);
	endtask

	// random received frame: good or bad check byte, early end, trailing bytes
	task automatic gen_parse_frame();
		logic [7:0] ctl;
		logic [7:0] len;
		logic [7:0] acc;
		logic [7:0] v;
		int cut;
		int trail;
		int k;
		ctl = 8'($urandom);
		len = pick_count();
		acc = rot_xor(rot_xor(8'h00, ctl), len);
		cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, int'(len) + 1) : -1;
		send_item(ctl, 8'($urandom), cut == 0, PRED, '0);
		if (cut == 0)
			return;
		send_item(len, 8'($urandom), cut == 1, PRED, '0);
		if (cut == 1)
			return;
		for (k = 0; k < int'(len); k++) begin
			v = 8'($urandom);
			acc = rot_xor(acc, v);
			send_item(v, 8'($urandom), cut == k + 2, PRED, '0);
			if (cut == k + 2)
				return;
		end
		v = ($urandom_range(0, 3) == 0) ? 8'($urandom) : acc;
		trail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
		send_item(v, 8'($urandom), trail == 0, PRED, '0);
		for (k = 1; k <= trail; k++)
			send_item(8'($urandom), 8'($urandom), k == trail, PRED, '0);
	endtask

	// garbage bytes ending with an end-of-buffer mark
	task automatic gen_line_noise();
		int k;
		int len;
		len = $urandom_range(1, 4);
		for (k = 1; k <= len; k++)
			send_item(8'($urandom), 8'($urandom), k == len, PRED, '0);
	endtask

	// stretches without idling on either side
	initial begin
		forever begin
			repeat ($urandom_range(40, 400)) @(posedge clk);
			snd_burst = ($urandom_range(0, 3) == 0);
			rcv_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// result side: random stall before each result
	initial begin : result_sink
		int stall;
		res_ch.ready = 1'b0;
		forever begin
			stall = rcv_burst ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				@(negedge clk) res_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (frame_results.size() == 0) begin
				$error("unexpected result: byte_out %0h kind %0d status %0d frame_end %0d",
					res_ch.byte_out, res_ch.kind, res_ch.status, res_ch.frame_end);
				errors++;
			end else begin
				want = frame_results.pop_front();
				if (res_ch.byte_out !== want.byte_out) begin
					$error("byte_out: expected %0h, actual %0h", want.byte_out, res_ch.byte_out);
					errors++;
				end
				if (res_ch.kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, res_ch.kind);
					errors++;
				end
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, res_ch.status);
					errors++;
				end
				if (res_ch.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, actual %0d", want.frame_end,
						res_ch.frame_end);
					errors++;
				end
			end
		end
	end

	// run limit
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("snp_frame_codec_core: mismatch");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int phase;
		int budget;
		logic [CFG_DATA_W-1:0] max_val;
		item_ch.valid      = 1'b0;
		item_ch.byte_in    = '0;
		item_ch.data_count = '0;
		item_ch.last_in    = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		arst_n             = 1'b0;
		errors             = 0;
		sent_items         = 0;
		cfg_dir            = DIR_BUILD;
		cfg_max            = MAX_FRAME_RST;
		clear_frame();

		// build mode at reset settings: empty frame, full-size frame, small frame
		add_fixed(8'hFF, 8'h00, 1'b0, 0, 3, res_of(8'hFF, KIND_CONTROL, ST_OK, 1'b0),
			res_of(8'h00, KIND_LENGTH, ST_OK, 1'b0), res_of(8'hFF, KIND_BCC, ST_OK, 1'b1));
		add_fixed(8'h00, 8'hFF, 1'b1, 255, 2, res_of(8'h00, KIND_CONTROL, ST_OK, 1'b0),
			res_of(8'hFF, KIND_LENGTH, ST_OK, 1'b0), NO_RES);
		add_pred(8'hA5, 8'h02, 1'b0, 0);
		add_pred(8'h5A, 8'hFF, 1'b1, 0);
		add_pred(8'h00, 8'h00, 1'b0, 0);
		// capacity overflow drops the data, exact fit passes
		add_cfg(REG_MAX_FRAME, 9'd4);
		add_fixed(8'h3C, 8'h02, 1'b0, 0, 1, res_of(8'h00, KIND_STATUS, ST_CAPACITY, 1'b1),
			NO_RES, NO_RES);
		add_fixed(8'h11, 8'h00, 1'b1, 0, 0, NO_RES, NO_RES, NO_RES);
		add_fixed(8'h22, 8'h7F, 1'b0, 0, 0, NO_RES, NO_RES, NO_RES);
		add_pred(8'h3C, 8'h01, 1'b0, 0);
		add_pred(8'hFF, 8'h00, 1'b0, 0);
		// limit below the overhead fails even an empty frame
		add_cfg(REG_MAX_FRAME, 9'd0);
		add_fixed(8'h77, 8'h00, 1'b0, 0, 1, res_of(8'h00, KIND_STATUS, ST_CAPACITY, 1'b1),
			NO_RES, NO_RES);
		// open the limit wide; writes to unused indexes change nothing
		add_cfg(REG_MAX_FRAME, 9'h1FF);
		add_cfg(REG_SPARE_LO, 9'h1FF);
		add_cfg(REG_SPARE_HI, 9'h000);
		add_fixed(8'h00, 8'h00, 1'b0, 0, 3, res_of(8'h00, KIND_CONTROL, ST_OK, 1'b0),
			res_of(8'h00, KIND_LENGTH, ST_OK, 1'b0), res_of(8'h00, KIND_BCC, ST_OK, 1'b1));
		// frame left open, dropped by the direction write
		add_pred(8'h12, 8'h05, 1'b0, 0);
		add_cfg(REG_DIRECTION, {8'h00, DIR_PARSE});
		// parse: good check byte
		add_pred(8'h01, 8'h00, 1'b0, 0);
		add_pred(8'h01, 8'hFF, 1'b0, 0);
		add_pred(8'hAB, 8'h00, 1'b0, 0);
		add_fixed(8'h5B, 8'h00, 1'b1, 0, 1, res_of(8'h5B, KIND_BCC, ST_OK, 1'b1),
			NO_RES, NO_RES);
		// bad check byte, then a trailing byte ending the buffer
		add_pred(8'h00, 8'h00, 1'b0, 0);
		add_pred(8'h00, 8'h00, 1'b0, 0);
		add_fixed(8'hFF, 8'h00, 1'b0, 0, 1, res_of(8'hFF, KIND_BCC, ST_MISMATCH, 1'b1),
			NO_RES, NO_RES);
		add_fixed(8'h34, 8'h00, 1'b1, 0, 0, NO_RES, NO_RES, NO_RES);
		// buffer ends inside the data
		add_pred(8'h55, 8'h00, 1'b0, 0);
		add_pred(8'h03, 8'h00, 1'b0, 0);
		add_fixed(8'h99, 8'h00, 1'b1, 0, 2, res_of(8'h99, KIND_DATA, ST_OK, 1'b0),
			res_of(8'h00, KIND_STATUS, ST_SHORT, 1'b1), NO_RES);
		// longest received frame
		add_pred(8'hC3, 8'h00, 1'b0, 0);
		add_pred(8'hFF, 8'h00, 1'b0, 255);
		add_pred(8'hA0, 8'h00, 1'b1, 0);
		// parse frame abandoned by rewriting direction, buffer ends on control
		add_pred(8'h10, 8'h00, 1'b0, 0);
		add_cfg(REG_DIRECTION, {8'hFF, DIR_PARSE});
		add_fixed(8'h20, 8'h00, 1'b1, 0, 2, res_of(8'h20, KIND_CONTROL, ST_OK, 1'b0),
			res_of(8'h00, KIND_STATUS, ST_SHORT, 1'b1), NO_RES);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].wdata);
			end else begin
				send_item(dir_rows[i].b, dir_rows[i].cnt, dir_rows[i].last, dir_rows[i].n_fix,
					dir_rows[i].fix);
				repeat (dir_rows[i].fill)
					send_item(8'($urandom), 8'($urandom),
						(cfg_dir == DIR_BUILD) ? 1'($urandom) : 1'b0, PRED, '0);
			end
		end

		// random phases, alternating direction, counting every request sent
		sent_items = 0;
		phase = 0;
		while (sent_items < RANDOM_ITEMS) begin
			settle();
			write_reg(REG_DIRECTION, {8'($urandom), (phase % 2 == 0) ? DIR_BUILD : DIR_PARSE});
			case ($urandom_range(0, 7))
				0: max_val = 9'd0;
				1: max_val = 9'd2;
				2: max_val = 9'd3;
				3: max_val = 9'd258;
				4: max_val = 9'h1FF;
				5: max_val = 9'($urandom_range(3, 12));
				6: max_val = 9'($urandom_range(10, 40));
				default: max_val = 9'($urandom);
			endcase
			write_reg(REG_MAX_FRAME, max_val);
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 9'($urandom));
			budget = sent_items + 70;
			while (sent_items < budget && sent_items < RANDOM_ITEMS) begin
				if ($urandom_range(0, 11) == 0)
					gen_line_noise();
				else if (cfg_dir == DIR_BUILD)
					gen_build_frame();
				else
					gen_parse_frame();
			end
			phase++;
		end

		settle();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("snp_frame_codec_core: match");
		else
			$display("snp_frame_codec_core: mismatch");
		$finish;
	end

endmodule
